// ----- design/pfts_pkg.sv -----
// Package for the periodic frame transmit scheduler: opcodes, states, table entry and control types.
`default_nettype none
package pfts_pkg;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	localparam logic [7:0] COUNT_FOREVER = 8'd255;
	localparam logic [4:0] MAX_RESULTS   = 5'd16;

	typedef struct packed {
		logic [10:0] id;
		logic [3:0]  length;
		logic [15:0] ivl_less_one;
		logic [31:0] last_time;
		logic [7:0]  remaining;
		logic [63:0] payload;
	} entry_t;

	typedef struct packed {
		logic wr_en;     // write the entry at the write address
		logic set_valid; // a load: mark entry and payload valid
		logic clr_pay;   // zero every payload
		logic rd_en;     // read the entry at the read address
	} tbl_ctrl_t;

endpackage
`default_nettype wire

// ----- design/pfts_table.sv -----
// Frame table: synchronous memory with per-entry valid bits so unwritten entries read as zero.
`default_nettype none
module pfts_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pfts_pkg::tbl_ctrl_t ctrl,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire pfts_pkg::entry_t  wr_data,
	input  wire logic [AW-1:0]     rd_addr,
	output pfts_pkg::entry_t       rd_data
);

	pfts_pkg::entry_t mem [DEPTH];
	pfts_pkg::entry_t rd_s1;
	logic [DEPTH-1:0] ent_vld_q;
	logic [DEPTH-1:0] pay_vld_q;
	logic             ent_vld_s1;
	logic             pay_vld_s1;

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q  <= '0;
			pay_vld_q  <= '0;
			ent_vld_s1 <= 1'b0;
			pay_vld_s1 <= 1'b0;
		end else begin
			if (ctrl.clr_pay) begin
				pay_vld_q <= '0;
			end else if (ctrl.wr_en && ctrl.set_valid) begin
				ent_vld_q[wr_addr] <= 1'b1;
				pay_vld_q[wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				ent_vld_s1 <= ent_vld_q[rd_addr];
				pay_vld_s1 <= pay_vld_q[rd_addr];
			end
		end
	end

	always_comb begin
		rd_data = '0;
		if (ent_vld_s1) begin
			rd_data = rd_s1;
			if (!pay_vld_s1) begin
				rd_data.payload = '0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/periodic_frame_tx_scheduler.sv -----
// Load, clear and unused opcodes finish in the accept cycle; busy stays low.
// A tick holds busy while the table is read one entry per cycle
// through its single read port, and each entry is checked and written back in the cycle after.
// Frames come one per strobe; each is held in a pending register so the final one can carry last.
// A new tick is accepted only once busy is low again. Reset empties the table (all entries
// disabled, all fields zero) at once through valid bits; no clearing pass.
`default_nettype none
module periodic_frame_tx_scheduler #(
	parameter int NUM_ENTRIES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  opcode,
	input  wire logic [3:0]  entry_index,
	input  wire logic [10:0] frame_id,
	input  wire logic [3:0]  frame_length,
	input  wire logic [15:0] interval_ms,
	input  wire logic [31:0] start_time,
	input  wire logic [7:0]  send_count,
	input  wire logic [63:0] payload,
	input  wire logic [31:0] now_ms,
	input  wire logic [4:0]  accept_limit,
	output logic             sent,
	output logic [3:0]       sent_index,
	output logic [10:0]      out_id,
	output logic [3:0]       out_length,
	output logic [63:0]      out_payload,
	output logic             last
);

	localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES - 1);

	pfts_pkg::state_t    state_q, state_d;
	pfts_pkg::tbl_ctrl_t ctrl;
	pfts_pkg::entry_t    wr_data, rd_data;
	logic [IW-1:0]       wr_addr;

	logic          accept;
	logic          load_ok;
	logic [IW+3:0] load_idx_ext;
	logic [IW-1:0] rd_idx_q;
	logic          rd_more_q;
	logic          v_s1;
	logic [IW-1:0] idx_s1;
	logic [31:0]   now_q;
	logic [4:0]    budget_q;
	logic [4:0]    sent_n_q;
	logic [4:0]    budget_in;
	logic          due;
	logic          do_send;
	logic          emit;
	logic          emit_last;

	logic          pend_v_q;
	logic [IW-1:0] pend_idx_q;
	logic [10:0]   pend_id_q;
	logic [3:0]    pend_len_q;
	logic [63:0]   pend_pay_q;
	logic [IW+3:0] pend_idx_ext;

	assign busy   = (state_q != pfts_pkg::ST_IDLE);
	assign accept = start && !busy;

	assign load_idx_ext = {{IW{1'b0}}, entry_index};
	assign load_ok      = (32'(entry_index) < NUM_ENTRIES);
	assign budget_in    = (accept_limit > pfts_pkg::MAX_RESULTS) ? pfts_pkg::MAX_RESULTS
	                                                              : accept_limit;

	// 33-bit sum so the due time never wraps
	assign due     = ({1'b0, now_q} > ({1'b0, rd_data.last_time} + {17'b0, rd_data.ivl_less_one}));
	assign do_send = v_s1 && due && (rd_data.remaining != 8'd0) && (sent_n_q < budget_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		wr_addr   = idx_s1;
		wr_data   = rd_data;
		emit      = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			pfts_pkg::ST_IDLE: begin
				if (accept) begin
					case (opcode)
						pfts_pkg::OP_LOAD: begin
							ctrl.wr_en        = load_ok;
							ctrl.set_valid    = 1'b1;
							wr_addr           = load_idx_ext[IW-1:0];
							wr_data.id        = frame_id;
							wr_data.length    = frame_length;
							wr_data.ivl_less_one = interval_ms - 16'd1;
							wr_data.last_time = start_time;
							wr_data.remaining = send_count;
							wr_data.payload   = payload;
						end
						pfts_pkg::OP_TICK:  state_d = pfts_pkg::ST_SCAN;
						pfts_pkg::OP_CLEAR: ctrl.clr_pay = 1'b1;
						default: ;
					endcase
				end
			end
			pfts_pkg::ST_SCAN: begin
				ctrl.rd_en = rd_more_q;
				if (do_send) begin
					ctrl.wr_en        = 1'b1;
					wr_data.last_time = now_q;
					if (rd_data.remaining != pfts_pkg::COUNT_FOREVER) begin
						wr_data.remaining = rd_data.remaining - 8'd1;
					end
					emit = pend_v_q;
				end
				if (v_s1 && (idx_s1 == LAST_IDX)) begin
					state_d = pfts_pkg::ST_FLUSH;
				end
			end
			pfts_pkg::ST_FLUSH: begin
				emit      = pend_v_q;
				emit_last = 1'b1;
				state_d   = pfts_pkg::ST_IDLE;
			end
			default: state_d = pfts_pkg::ST_IDLE;
		endcase
	end

	pfts_table #(
		.DEPTH (NUM_ENTRIES),
		.AW    (IW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_idx_q),
		.rd_data (rd_data)
	);

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_more_q <= 1'b0;
			v_s1      <= 1'b0;
			sent_n_q  <= '0;
			pend_v_q  <= 1'b0;
			sent      <= 1'b0;
		end else begin
			v_s1 <= ctrl.rd_en;
			sent <= emit;
			if (accept && (opcode == pfts_pkg::OP_TICK)) begin
				rd_idx_q  <= '0;
				rd_more_q <= 1'b1;
				sent_n_q  <= '0;
			end else if (ctrl.rd_en) begin
				rd_idx_q <= rd_idx_q + IW'(1);
				if (rd_idx_q == LAST_IDX) begin
					rd_more_q <= 1'b0;
				end
			end
			if (do_send) begin
				sent_n_q <= sent_n_q + 5'd1;
				pend_v_q <= 1'b1;
			end else if (state_q == pfts_pkg::ST_FLUSH) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	assign pend_idx_ext = {4'b0, pend_idx_q};

	always_ff @(posedge clk) begin
		if (accept && (opcode == pfts_pkg::OP_TICK)) begin
			now_q    <= now_ms;
			budget_q <= budget_in;
		end
		idx_s1 <= rd_idx_q;
		if (do_send) begin
			pend_idx_q <= idx_s1;
			pend_id_q  <= rd_data.id;
			pend_len_q <= rd_data.length;
			pend_pay_q <= rd_data.payload;
		end
		if (emit) begin
			sent_index  <= pend_idx_ext[3:0];
			out_id      <= pend_id_q;
			out_length  <= pend_len_q;
			out_payload <= pend_pay_q;
			last        <= emit_last;
		end
	end

endmodule
`default_nettype wire

// ----- sim/tb_periodic_frame_tx_scheduler.sv -----
// Self-checking testbench for the periodic frame transmit scheduler: table model, stimulus and checks.
`timescale 1ns / 100ps

typedef struct {
	pfts_pkg::opcode_t op;
	logic [3:0]        idx;
	logic [10:0]       id;
	logic [3:0]        len;
	logic [15:0]       ivl;
	logic [31:0]       st;
	logic [7:0]        cnt;
	logic [63:0]       pay;
	logic [31:0]       now;
	logic [4:0]        lim;
} sched_cmd_t;

typedef struct {
	logic [3:0]  idx;
	logic [10:0] id;
	logic [3:0]  len;
	logic [63:0] pay;
	logic        last;
} frame_t;

class frame_scoreboard;
	localparam int ENTRIES = 16;

	logic [10:0] tbl_id [ENTRIES];
	logic [3:0]  tbl_len [ENTRIES];
	logic [15:0] tbl_ivl_m1 [ENTRIES];
	logic [31:0] tbl_last [ENTRIES];
	logic [7:0]  tbl_left [ENTRIES];
	logic [63:0] tbl_pay [ENTRIES];

	frame_t due_frames[$];
	int     mismatches;
	int     frames_checked;
	int     commands;
	int     ticks;

	function new();
		for (int k = 0; k < ENTRIES; k++) begin
			tbl_id[k]     = '0;
			tbl_len[k]    = '0;
			tbl_ivl_m1[k] = '0;
			tbl_last[k]   = '0;
			tbl_left[k]   = '0;
			tbl_pay[k]    = '0;
		end
		mismatches     = 0;
		frames_checked = 0;
		commands       = 0;
		ticks          = 0;
	endfunction

	// Update the table for an accepted transaction; a tick queues the frames it sends.
	function void note_command(sched_cmd_t c);
		logic [32:0] due_after;
		int          budget;
		int          n;
		frame_t      f;
		frame_t      burst[$];
		commands++;
		case (c.op)
			pfts_pkg::OP_LOAD: begin
				if (int'(c.idx) < ENTRIES) begin
					tbl_id[c.idx]     = c.id;
					tbl_len[c.idx]    = c.len;
					tbl_ivl_m1[c.idx] = c.ivl - 16'd1;
					tbl_last[c.idx]   = c.st;
					tbl_left[c.idx]   = c.cnt;
					tbl_pay[c.idx]    = c.pay;
				end
			end
			pfts_pkg::OP_CLEAR: begin
				for (int k = 0; k < ENTRIES; k++)
					tbl_pay[k] = '0;
			end
			pfts_pkg::OP_TICK: begin
				ticks++;
				budget = (c.lim > pfts_pkg::MAX_RESULTS) ? int'(pfts_pkg::MAX_RESULTS) : int'(c.lim);
				n = 0;
				for (int k = 0; k < ENTRIES; k++) begin
					// 33-bit sum: a late start never wraps around to look due
					due_after = {1'b0, tbl_last[k]} + {17'd0, tbl_ivl_m1[k]};
					if ({1'b0, c.now} > due_after && tbl_left[k] != 8'd0 && n < budget) begin
						f.idx  = 4'(k);
						f.id   = tbl_id[k];
						f.len  = tbl_len[k];
						f.pay  = tbl_pay[k];
						f.last = 1'b0;
						burst.push_back(f);
						n++;
						tbl_last[k] = c.now;
						if (tbl_left[k] != pfts_pkg::COUNT_FOREVER)
							tbl_left[k] = tbl_left[k] - 8'd1;
					end
				end
				if (n > 0)
					burst[n - 1].last = 1'b1;
				foreach (burst[i])
					due_frames.push_back(burst[i]);
			end
			default: ;
		endcase
	endfunction

	function void check_frame(frame_t got);
		frame_t want;
		if (due_frames.size() == 0) begin
			$error("unexpected frame from entry %0d, id %h", got.idx, got.id);
			mismatches++;
			return;
		end
		want = due_frames.pop_front();
		frames_checked++;
		if (got.idx !== want.idx) begin
			$error("sent_index: expected %0d, got %0d", want.idx, got.idx);
			mismatches++;
		end
		if (got.id !== want.id) begin
			$error("out_id: expected %h, got %h", want.id, got.id);
			mismatches++;
		end
		if (got.len !== want.len) begin
			$error("out_length: expected %0d, got %0d", want.len, got.len);
			mismatches++;
		end
		if (got.pay !== want.pay) begin
			$error("out_payload: expected %h, got %h", want.pay, got.pay);
			mismatches++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %b, got %b", want.last, got.last);
			mismatches++;
		end
	endfunction

	function int pending();
		return due_frames.size();
	endfunction
endclass

module tb_periodic_frame_tx_scheduler;

	localparam int NUM_ENTRIES = 16;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n       = 1'b0;
	logic        start        = 1'b0;
	logic [1:0]  opcode       = '0;
	logic [3:0]  entry_index  = '0;
	logic [10:0] frame_id     = '0;
	logic [3:0]  frame_length = '0;
	logic [15:0] interval_ms  = '0;
	logic [31:0] start_time   = '0;
	logic [7:0]  send_count   = '0;
	logic [63:0] payload      = '0;
	logic [31:0] now_ms       = '0;
	logic [4:0]  accept_limit = '0;
	logic        busy;
	logic        sent;
	logic [3:0]  sent_index;
	logic [10:0] out_id;
	logic [3:0]  out_length;
	logic [63:0] out_payload;
	logic        last;

	frame_scoreboard sb = new();
	int          idle_pct = 0;
	int          cycles   = 0;
	logic [31:0] clock_ms = '0;
	sched_cmd_t  seen_cmd;
	frame_t      seen_frame;

	periodic_frame_tx_scheduler #(
		.NUM_ENTRIES(NUM_ENTRIES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.entry_index(entry_index),
		.frame_id(frame_id),
		.frame_length(frame_length),
		.interval_ms(interval_ms),
		.start_time(start_time),
		.send_count(send_count),
		.payload(payload),
		.now_ms(now_ms),
		.accept_limit(accept_limit),
		.sent(sent),
		.sent_index(sent_index),
		.out_id(out_id),
		.out_length(out_length),
		.out_payload(out_payload),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Frames are checked before a same-edge transaction is noted; they belong to older ticks.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sent === 1'b1) begin
				seen_frame.idx  = sent_index;
				seen_frame.id   = out_id;
				seen_frame.len  = out_length;
				seen_frame.pay  = out_payload;
				seen_frame.last = last;
				sb.check_frame(seen_frame);
			end
			if (start === 1'b1 && busy === 1'b0) begin
				seen_cmd.op  = pfts_pkg::opcode_t'(opcode);
				seen_cmd.idx = entry_index;
				seen_cmd.id  = frame_id;
				seen_cmd.len = frame_length;
				seen_cmd.ivl = interval_ms;
				seen_cmd.st  = start_time;
				seen_cmd.cnt = send_count;
				seen_cmd.pay = payload;
				seen_cmd.now = now_ms;
				seen_cmd.lim = accept_limit;
				sb.note_command(seen_cmd);
			end
		end
	end

	function automatic sched_cmd_t rand_cmd(pfts_pkg::opcode_t op);
		sched_cmd_t c;
		c.op  = op;
		c.idx = 4'($urandom);
		c.id  = 11'($urandom);
		c.len = 4'($urandom);
		c.ivl = 16'($urandom);
		c.st  = $urandom;
		c.cnt = 8'($urandom);
		c.pay = {$urandom, $urandom};
		c.now = $urandom;
		c.lim = 5'($urandom);
		return c;
	endfunction

	function automatic sched_cmd_t mk_load(logic [3:0] idx, logic [10:0] id, logic [3:0] len,
			logic [15:0] ivl, logic [31:0] st, logic [7:0] cnt, logic [63:0] pay);
		sched_cmd_t c;
		c     = rand_cmd(pfts_pkg::OP_LOAD);
		c.idx = idx;
		c.id  = id;
		c.len = len;
		c.ivl = ivl;
		c.st  = st;
		c.cnt = cnt;
		c.pay = pay;
		return c;
	endfunction

	function automatic sched_cmd_t mk_tick(logic [31:0] now, logic [4:0] lim);
		sched_cmd_t c;
		c     = rand_cmd(pfts_pkg::OP_TICK);
		c.now = now;
		c.lim = lim;
		return c;
	endfunction

	// Start stays high from one transaction to the next unless a gap is taken.
	task automatic issue(input sched_cmd_t c);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start        <= 1'b1;
		opcode       <= c.op;
		entry_index  <= c.idx;
		frame_id     <= c.id;
		frame_length <= c.len;
		interval_ms  <= c.ivl;
		start_time   <= c.st;
		send_count   <= c.cnt;
		payload      <= c.pay;
		now_ms       <= c.now;
		accept_limit <= c.lim;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Mostly loads near the running time and ticks that advance it, so entries fall due often.
	task automatic random_phase(input int count, input int pct);
		sched_cmd_t c;
		int         sel;
		int         r;
		idle_pct = pct;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			r   = $urandom_range(9);
			if (sel < 38) begin
				c = rand_cmd(pfts_pkg::OP_LOAD);
				if (r < 7)
					c.ivl = 16'($urandom_range(30));
				else if (r == 9)
					c.ivl = 16'd0;
				r = $urandom_range(9);
				if (r < 7)
					c.st = clock_ms - 32'($urandom_range(40));
				else if (r < 8)
					c.st = clock_ms + 32'($urandom_range(20));
				r = $urandom_range(9);
				if (r < 4)
					c.cnt = pfts_pkg::COUNT_FOREVER;
				else if (r < 8)
					c.cnt = 8'($urandom_range(1, 4));
				else if (r < 9)
					c.cnt = 8'd0;
				if ($urandom_range(9) < 9)
					c.len = 4'($urandom_range(8));
			end else if (sel < 88) begin
				if (r < 8)
					clock_ms = clock_ms + 32'($urandom_range(25));
				else if (r < 9)
					clock_ms = $urandom;
				else
					clock_ms = clock_ms + 32'd70000;
				c = mk_tick(clock_ms, ($urandom_range(9) < 6) ?
					5'($urandom_range(1, 16)) : 5'($urandom));
			end else if (sel < 94) begin
				c = rand_cmd(pfts_pkg::OP_CLEAR);
			end else begin
				c = rand_cmd(pfts_pkg::OP_NONE);
			end
			issue(c);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 0;
		issue(mk_tick(32'd0, 5'd16));
		// interval zero is kept as 65535
		issue(mk_load(4'd0, 11'h7FF, 4'd8, 16'd0, 32'd0, pfts_pkg::COUNT_FOREVER, '1));
		issue(mk_load(4'd15, 11'h000, 4'd15, 16'd1, 32'd0, 8'd1, 64'd0));
		// start plus interval beyond 32 bits: never due
		issue(mk_load(4'd5, 11'h2AA, 4'd4, 16'hFFFF, 32'hFFFF_FFFF, 8'd3,
			64'h0123_4567_89AB_CDEF));
		issue(mk_load(4'd3, 11'h555, 4'd2, 16'd10, 32'd100, 8'd0, 64'hFEDC_BA98_7654_3210));
		issue(mk_tick(32'd65535, 5'd16));
		issue(mk_tick(32'd65536, 5'd31));
		for (int i = 0; i < 4; i++)
			issue(mk_load(4'(6 + i), 11'(12'h100 * i + 1), 4'(i + 1), 16'd1, 32'd0, 8'd2,
				{$urandom, $urandom}));
		issue(mk_tick(32'd70000, 5'd0));
		issue(mk_tick(32'd70001, 5'd2));
		issue(mk_tick(32'd70002, 5'd20));
		issue(rand_cmd(pfts_pkg::OP_CLEAR));
		issue(mk_tick(32'd200000, 5'd16));
		issue(rand_cmd(pfts_pkg::OP_NONE));
		issue(mk_load(4'd10, 11'h3C3, 4'd7, 16'd0, 32'hFFFF_0000, pfts_pkg::COUNT_FOREVER, '1));
		issue(mk_tick(32'hFFFF_FFFF, 5'd16));
		issue(mk_tick(32'hFFFF_FFFF, 5'd1));
		clock_ms = 32'd300000;

		random_phase(70, 0);
		random_phase(65, 81);
		random_phase(65, 6);
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (NUM_ENTRIES + 6) @(posedge clk);

		$display("Covered %0d transactions, %0d of them ticks, and checked %0d frames.",
			sb.commands, sb.ticks, sb.frames_checked);
		$display("Loads, clears, unused opcode, budget cap and starvation, and 33-bit due times.");
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
